// ===== rtl/core/tkst_pkg.sv =====
// Shared types, constants and helpers of the ranked score tables.
package tkst_pkg;

    localparam int TABLES     = 8;
    localparam int SLOTS      = 5;
    localparam int NAME_CHARS = 3;

    localparam int FUNC_W  = 2;
    localparam int SEL_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int NAME_W  = 24;
    localparam int SCORE_W = 32;
    localparam int CNT_W   = 3;
    localparam int TAB_W   = (TABLES > 1) ? $clog2(TABLES) : 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_QUALIFY = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [NAME_W-1:0]  name;
    } slot_t;

    typedef slot_t [SLOTS-1:0] row_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TAB_W-1:0]   tab;
        logic               tab_ok;
        logic [SLOT_W-1:0]  slot_index;
        logic [NAME_W-1:0]  entry_name;
        logic [SCORE_W-1:0] entry_score;
    } op_t;

    typedef struct packed {
        logic               qualifies;
        logic [SLOT_W-1:0]  rank_taken;
        logic               read_valid;
        logic [NAME_W-1:0]  read_name;
        logic [SCORE_W-1:0] read_score;
        logic [CNT_W-1:0]   entry_count;
    } rsp_t;

    // Zero every character after the first zero character.
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              ended;
        res   = '0;
        ended = 1'b0;
        for (int i = NAME_CHARS - 1; i >= 0; i--)
        begin
            if (raw[8*i +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/tkst_if.sv =====
// Valid/ready channels carrying request and response beats.
interface tkst_req_if
    import tkst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [SEL_W-1:0]   table_select;
    logic [SLOT_W-1:0]  slot_index;
    logic [NAME_W-1:0]  entry_name;
    logic [SCORE_W-1:0] entry_score;

    modport source (output valid, func, table_select, slot_index, entry_name, entry_score,
                    input ready);
    modport sink   (input valid, func, table_select, slot_index, entry_name, entry_score,
                    output ready);
endinterface

interface tkst_rsp_if
    import tkst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               qualifies;
    logic [SLOT_W-1:0]  rank_taken;
    logic               read_valid;
    logic [NAME_W-1:0]  read_name;
    logic [SCORE_W-1:0] read_score;
    logic [CNT_W-1:0]   entry_count;

    modport source (output valid, qualifies, rank_taken, read_valid, read_name, read_score,
                    entry_count, input ready);
    modport sink   (input valid, qualifies, rank_taken, read_valid, read_name, read_score,
                    entry_count, output ready);
endinterface

// ===== rtl/core/top_k_sorted_insert_tables.sv =====
// Top level of the ranked score tables: row memory, insert/query sequencer, response register.
//
// Usage:
//   req (sink)  : one beat per operation: func, table_select, slot_index,
//                 entry_name, entry_score. func selects insert, qualify,
//                 read slot or clear all tables.
//   rsp (source): exactly one beat per request: qualifies, rank_taken,
//                 read_valid, read_name, read_score, entry_count.
//   Each table is one row of the slot memory (all slots of the list side
//   by side); fill counts sit in flip-flops.
//   Flow: an accepted request is held in the operand and row-read registers;
//   the exec state compares, shifts and writes the row back and registers
//   the response. A new request is taken only in the idle state, so the
//   block finishes one request before it accepts the next.
//   Reset: all fill counts go to zero, which empties every list at once;
//   row contents past a list's count are never looked at, so the memory
//   needs no clearing pass. Clear does the same.
//   Stall: the response stays in its register until taken; a finished
//   operation waits in the compute state, and req.ready stays low, until
//   the response register frees up.
module top_k_sorted_insert_tables
    import tkst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tkst_req_if.sink  req,
    tkst_rsp_if.source rsp
);

    row_t             row_mem [TABLES];
    row_t             row_rd_reg;
    op_t              op_reg;
    logic [CNT_W-1:0] cnt_reg [TABLES];
    state_t           state_reg;
    state_t           state_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             req_fire;
    logic [TAB_W-1:0] req_tab;
    logic             exec_done;
    logic             wr_en;
    row_t             row_next;
    logic             cnt_wr;
    logic             cnt_clear;
    logic [CNT_W-1:0] cnt_new;
    rsp_t             rsp_next;

    // Per-op compute terms.
    logic [CNT_W-1:0] n;
    logic [SLOT_W-1:0] at;
    logic             found;
    logic             placed;
    slot_t            rd_slot;

    assign req_tab  = TAB_W'(req.table_select);
    assign req_fire = req.valid && req.ready;

    // Row memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[op_reg.tab] <= row_next;
        end
        if (req_fire)
        begin
            row_rd_reg <= row_mem[req_tab];
            op_reg.func        <= req.func;
            op_reg.tab         <= req_tab;
            op_reg.tab_ok      <= (int'(req.table_select) < TABLES);
            op_reg.slot_index  <= req.slot_index;
            op_reg.entry_name  <= req.entry_name;
            op_reg.entry_score <= req.entry_score;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TABLES; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else if (cnt_clear)
        begin
            for (int t = 0; t < TABLES; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else if (cnt_wr)
        begin
            cnt_reg[op_reg.tab] <= cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        exec_done  = 1'b0;
        wr_en      = 1'b0;
        cnt_wr     = 1'b0;
        cnt_clear  = 1'b0;
        cnt_new    = '0;
        row_next   = row_rd_reg;
        n          = op_reg.tab_ok ? cnt_reg[op_reg.tab] : '0;
        at         = SLOT_W'(n);
        found      = 1'b0;
        rd_slot    = '0;

        // Find the first kept slot with a strictly lower score.
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && (i < int'(n)) && (op_reg.entry_score > row_rd_reg[i].score))
            begin
                at    = SLOT_W'(i);
                found = 1'b1;
            end
        end
        placed = (int'(at) < SLOTS);

        // Shift lower entries down and drop in the new one.
        for (int i = 1; i < SLOTS; i++)
        begin
            if (i > int'(at))
            begin
                row_next[i] = row_rd_reg[i-1];
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i == int'(at))
            begin
                row_next[i].score = op_reg.entry_score;
                row_next[i].name  = clean_name(op_reg.entry_name);
            end
        end

        for (int i = 0; i < SLOTS; i++)
        begin
            if (i == int'(op_reg.slot_index))
            begin
                rd_slot = row_rd_reg[i];
            end
        end

        rsp_next             = '0;
        rsp_next.rank_taken  = SLOT_W'(SLOTS);
        rsp_next.entry_count = n;

        case (func_t'(op_reg.func))
            FUNC_INSERT:
            begin
                if (op_reg.tab_ok && placed)
                begin
                    cnt_new              = (int'(n) < SLOTS) ? n + CNT_W'(1) : n;
                    rsp_next.qualifies   = 1'b1;
                    rsp_next.rank_taken  = at;
                    rsp_next.entry_count = cnt_new;
                end
            end
            FUNC_QUALIFY:
            begin
                rsp_next.qualifies = op_reg.tab_ok &&
                    ((int'(n) < SLOTS) || (op_reg.entry_score > row_rd_reg[SLOTS-1].score));
            end
            FUNC_READ:
            begin
                if (op_reg.tab_ok && (op_reg.slot_index < n))
                begin
                    rsp_next.read_valid = 1'b1;
                    rsp_next.read_name  = rd_slot.name;
                    rsp_next.read_score = rd_slot.score;
                end
            end
            FUNC_CLEAR:
            begin
                rsp_next.entry_count = '0;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Hold until the response register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    exec_done  = 1'b1;
                    state_next = ST_IDLE;
                    if (func_t'(op_reg.func) == FUNC_CLEAR)
                    begin
                        cnt_clear = 1'b1;
                    end
                    else if ((func_t'(op_reg.func) == FUNC_INSERT) && op_reg.tab_ok && placed)
                    begin
                        wr_en  = 1'b1;
                        cnt_wr = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.qualifies   = rsp_reg.qualifies;
    assign rsp.rank_taken  = rsp_reg.rank_taken;
    assign rsp.read_valid  = rsp_reg.read_valid;
    assign rsp.read_name   = rsp_reg.read_name;
    assign rsp.read_score  = rsp_reg.read_score;
    assign rsp.entry_count = rsp_reg.entry_count;

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the ranked score tables: directed and random beats vs a local model.
`timescale 1ns / 100ps

module testbench;
    import tkst_pkg::*;

    // One request beat as the driver presents it.
    typedef struct {
        func_t              func;
        logic [SEL_W-1:0]   table_select;
        logic [SLOT_W-1:0]  slot_index;
        logic [NAME_W-1:0]  entry_name;
        logic [SCORE_W-1:0] entry_score;
    } score_op_t;

    localparam int RANDOM_OPS  = 1350;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 10;

    logic clk;
    logic rst_n;

    tkst_req_if req_ch ();
    tkst_rsp_if rsp_ch ();

    top_k_sorted_insert_tables uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Pending request beats, filled up front and drained by the driver.
    score_op_t ops_pending[$];
    // Responses the tables should give, oldest first.
    rsp_t      responses_due[$];

    // Local copy of the ranked lists.
    logic [SCORE_W-1:0] rank_scores [TABLES][SLOTS];
    logic [NAME_W-1:0]  rank_names  [TABLES][SLOTS];
    int                 rank_fill   [TABLES];

    int   accepted_ops;
    int   total_ops;
    int   fail_count;
    int   idle_cycles;
    int   req_gap;
    int   rsp_hold;
    int   phase_left;
    logic steady;
    logic req_fire;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model of the tables
    // ------------------------------------------------------------------

    // Keep characters up to the first zero character; zero the rest.
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] keep;
        logic              live;
        keep = '0;
        live = 1'b1;
        for (int c = NAME_CHARS - 1; c >= 0; c--)
        begin
            live = live && (raw[8*c +: 8] != 8'h00);
            if (live)
            begin
                keep[8*c +: 8] = raw[8*c +: 8];
            end
        end
        return keep;
    endfunction

    function automatic void empty_tables();
        for (int t = 0; t < TABLES; t++)
        begin
            rank_fill[t] = 0;
            for (int s = 0; s < SLOTS; s++)
            begin
                rank_scores[t][s] = '0;
                rank_names[t][s]  = '0;
            end
        end
    endfunction

    // Apply one beat to the local lists and return the response it owes.
    function automatic rsp_t apply_to_tables(input score_op_t op);
        rsp_t res;
        int   t;
        int   n;
        int   at;
        int   last;
        res             = '0;
        res.rank_taken  = SLOT_W'(SLOTS);
        t               = int'(op.table_select);
        if (op.func == FUNC_CLEAR)
        begin
            empty_tables();
        end
        else if (t < TABLES)
        begin
            n = (rank_fill[t] > SLOTS) ? SLOTS : rank_fill[t];
            case (op.func)
                FUNC_INSERT:
                begin
                    // First slot strictly below the new score; ties land after.
                    at = n;
                    for (int i = n - 1; i >= 0; i--)
                    begin
                        if (op.entry_score > rank_scores[t][i])
                        begin
                            at = i;
                        end
                    end
                    if (at < SLOTS)
                    begin
                        last = (n < SLOTS) ? n : SLOTS - 1;
                        for (int i = last; i > at; i--)
                        begin
                            rank_scores[t][i] = rank_scores[t][i-1];
                            rank_names[t][i]  = rank_names[t][i-1];
                        end
                        rank_scores[t][at] = op.entry_score;
                        rank_names[t][at]  = trim_name(op.entry_name);
                        if (n < SLOTS)
                        begin
                            n++;
                        end
                        rank_fill[t]   = n;
                        res.qualifies  = 1'b1;
                        res.rank_taken = SLOT_W'(at);
                    end
                end
                FUNC_QUALIFY:
                begin
                    res.qualifies = (n < SLOTS) ||
                                    (op.entry_score > rank_scores[t][SLOTS-1]);
                end
                default:
                begin
                    if (int'(op.slot_index) < n)
                    begin
                        res.read_valid = 1'b1;
                        res.read_name  = rank_names[t][op.slot_index];
                        res.read_score = rank_scores[t][op.slot_index];
                    end
                end
            endcase
            res.entry_count = CNT_W'(n);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void queue_op(input func_t f, input int tab, input int slot,
                                     input logic [NAME_W-1:0] name,
                                     input logic [SCORE_W-1:0] score);
        score_op_t op;
        op.func         = f;
        op.table_select = SEL_W'(tab);
        op.slot_index   = SLOT_W'(slot);
        op.entry_name   = name;
        op.entry_score  = score;
        ops_pending.push_back(op);
    endfunction

    // Scores cluster in narrow bands so ties and full lists are common.
    function automatic logic [SCORE_W-1:0] random_score();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return SCORE_W'($urandom_range(0, 15));
        end
        else if (pick == 4)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return {{(SCORE_W-1){1'b1}}, 1'b0};
                default: return SCORE_W'(1);
            endcase
        end
        else if (pick < 7)
        begin
            return {{(SCORE_W-4){1'b1}}, 4'($urandom_range(0, 15))};
        end
        return SCORE_W'($urandom);
    endfunction

    // Names with an occasional zero character somewhere inside.
    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] name;
        name = NAME_W'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            for (int c = 0; c < NAME_CHARS; c++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    name[8*c +: 8] = 8'h00;
                end
            end
        end
        return name;
    endfunction

    function automatic void queue_random_op();
        int    pick;
        int    tab;
        func_t f;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            f = FUNC_INSERT;
        end
        else if (pick < 68)
        begin
            f = FUNC_QUALIFY;
        end
        else if (pick < 99)
        begin
            f = FUNC_READ;
        end
        else
        begin
            f = FUNC_CLEAR;
        end
        // Favor two tables so their lists fill and overflow.
        tab = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 1) : $urandom_range(0, 7);
        queue_op(f, tab, $urandom_range(0, 7), random_name(), random_score());
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long stretch; always back-to-back in a steady phase.
    function automatic int pick_gap();
        int pick;
        if (steady)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        else if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string fname, input logic [SCORE_W-1:0] want,
                                 input logic [SCORE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            fail_count++;
        end
    endtask

    // Switch at random between stretches with no idling and stretches with random gaps.
    always @(posedge clk)
    begin
        if (phase_left == 0)
        begin
            steady     <= ($urandom_range(0, 3) == 0);
            phase_left <= $urandom_range(50, 300);
        end
        else
        begin
            phase_left <= phase_left - 1;
        end
    end

    // Monitor: check response beats first, then predict for accepted requests.
    // A response never comes at the edge that accepts its request, so the order is safe.
    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (responses_due.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = responses_due.pop_front();
                    compare_field("qualifies", SCORE_W'(want.qualifies),
                                  SCORE_W'(rsp_ch.qualifies));
                    compare_field("rank_taken", SCORE_W'(want.rank_taken),
                                  SCORE_W'(rsp_ch.rank_taken));
                    compare_field("read_valid", SCORE_W'(want.read_valid),
                                  SCORE_W'(rsp_ch.read_valid));
                    compare_field("read_name", SCORE_W'(want.read_name),
                                  SCORE_W'(rsp_ch.read_name));
                    compare_field("read_score", want.read_score, rsp_ch.read_score);
                    compare_field("entry_count", SCORE_W'(want.entry_count),
                                  SCORE_W'(rsp_ch.entry_count));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                score_op_t op;
                op.func         = func_t'(req_ch.func);
                op.table_select = req_ch.table_select;
                op.slot_index   = req_ch.slot_index;
                op.entry_name   = req_ch.entry_name;
                op.entry_score  = req_ch.entry_score;
                responses_due.push_back(apply_to_tables(op));
                accepted_ops++;
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: advance on the falling edge, using the beat seen at the last rise
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        score_op_t op;
        if (rst_n && (!req_ch.valid || req_fire))
        begin
            if (req_gap > 0)
            begin
                req_gap = req_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (ops_pending.size() > 0)
            begin
                op = ops_pending.pop_front();
                req_ch.func         <= op.func;
                req_ch.table_select <= op.table_select;
                req_ch.slot_index   <= op.slot_index;
                req_ch.entry_name   <= op.entry_name;
                req_ch.entry_score  <= op.entry_score;
                req_ch.valid        <= 1'b1;
                req_gap = pick_gap();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response side: hold ready low for random stalls.
    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_hold = rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            rsp_hold = pick_gap();
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the queue, reset, wait for the drain, report
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_INSERT;
        req_ch.table_select = '0;
        req_ch.slot_index   = '0;
        req_ch.entry_name   = '0;
        req_ch.entry_score  = '0;
        rsp_ch.ready        = 1'b0;
        rst_n               = 1'b0;
        accepted_ops        = 0;
        fail_count          = 0;
        idle_cycles         = 0;
        req_gap             = 0;
        rsp_hold            = 0;
        phase_left          = 0;
        steady              = 1'b0;
        empty_tables();

        // Empty list: read misses, any score qualifies.
        queue_op(FUNC_READ,    0, 0, 24'h414243, 32'h0);
        queue_op(FUNC_QUALIFY, 0, 0, 24'h0,      32'h0);
        // Fill table 0 with extremes, ties and names cut by a zero character.
        queue_op(FUNC_INSERT,  0, 7, 24'hFFFFFF, 32'hFFFF_FFFF);
        queue_op(FUNC_INSERT,  0, 0, 24'h414243, 32'h0);
        queue_op(FUNC_INSERT,  0, 0, 24'h004142, 32'd100);
        queue_op(FUNC_INSERT,  0, 0, 24'h410042, 32'd100);
        queue_op(FUNC_INSERT,  0, 0, 24'h414200, 32'd100);
        // Full list: a score equal to the last slot stays out.
        queue_op(FUNC_INSERT,  0, 0, 24'h585858, 32'h0);
        queue_op(FUNC_QUALIFY, 0, 0, 24'h0,      32'h0);
        queue_op(FUNC_QUALIFY, 0, 0, 24'h0,      32'h1);
        // Drop the last entry.
        queue_op(FUNC_INSERT,  0, 0, 24'h5A5A5A, 32'd50);
        queue_op(FUNC_READ,    0, 0, 24'h0,      32'h0);
        queue_op(FUNC_READ,    0, 4, 24'h0,      32'h0);
        queue_op(FUNC_READ,    0, 5, 24'h0,      32'h0);
        queue_op(FUNC_READ,    0, 7, 24'h0,      32'h0);
        // Highest table, separate from table 0.
        queue_op(FUNC_INSERT,  7, 3, 24'h7F7F7F, 32'h1);
        queue_op(FUNC_READ,    7, 0, 24'h0,      32'h0);
        queue_op(FUNC_READ,    0, 1, 24'h0,      32'h0);
        // Clear empties everything.
        queue_op(FUNC_CLEAR,   5, 2, 24'hFFFFFF, 32'hFFFF_FFFF);
        queue_op(FUNC_READ,    0, 0, 24'h0,      32'h0);
        queue_op(FUNC_READ,    7, 0, 24'h0,      32'h0);
        queue_op(FUNC_QUALIFY, 0, 0, 24'h0,      32'h0);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            queue_random_op();
        end
        total_ops = ops_pending.size();

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Hold until every request has gone in and every response has come out.
        while (accepted_ops < total_ops || responses_due.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);

        if (fail_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
